[rtl/core/tape_memory_with_wrapping_pointer_unit_assert.svh]
// assertion macros of the tape rtl
`ifndef TAPE_MEMORY_WITH_WRAPPING_POINTER_UNIT_ASSERT_SVH
`define TAPE_MEMORY_WITH_WRAPPING_POINTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMWP_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TMWP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tmwp_pkg.sv]
// types and opcodes of the tape unit
package tmwp_pkg;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_MOVE  = 3'd1;
	localparam logic [2:0] OP_SET   = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] amount;
		logic [7:0]         byte_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               move_rejected;
	} rsp_t;

endpackage

[rtl/core/tmwp_ram.sv]
// single-port-write, registered-read cell store of the tape
module tmwp_ram #(
	parameter int DEPTH = 30000,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/tape_memory_with_wrapping_pointer_unit.sv]
// tape unit: cell store, head pointer and command sequencer
//
// Command channel cmd (cmd_valid/cmd_stall) carries one opcode beat: add to
// the cell at the head, move the head, set a byte, read the cell, or clear.
// Response channel rsp (rsp_valid/rsp_stall) returns exactly one beat per
// command: new cell value, head position, stored byte, cell value or 0.
// A move whose offset magnitude exceeds CELL_COUNT-1 leaves the head and
// returns it with move_rejected set; otherwise the head wraps round the tape.
// Every command but clear does one read-modify-write of the cell store: the read is
// issued on the accept edge; the write (add and set only) and the response register
// load follow in ST_EXEC once the response register is free, and no new command is
// taken until that response is loaded. Clear zeroes cells 0..head-1 one per cycle;
// the cell at the head is kept.
// After reset the store is swept to zero, one cell per cycle, with cmd_stall
// high throughout.
// A result waiting under rsp_stall sits in the response register; the next
// command is still accepted and held until that register frees.
module tape_memory_with_wrapping_pointer_unit #(
	parameter int CELL_COUNT = 30000
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tmwp_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tmwp_pkg::rsp_t rsp
);

	`include "tape_memory_with_wrapping_pointer_unit_assert.svh"

	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam logic signed [31:0]   LIM    = 32'(CELL_COUNT - 1);
	localparam logic signed [AW+1:0] CNT_S  = (AW+2)'(CELL_COUNT);
	localparam logic [AW-1:0]        LAST_A = AW'(CELL_COUNT - 1);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLR
	} state_t;

	state_t          state_q;
	tmwp_pkg::cmd_t  item_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   ptr_q;
	logic            rsp_valid_q;
	tmwp_pkg::rsp_t  rsp_q;

	logic            accept;
	logic            slot_free;
	logic            rsp_load;
	logic [31:0]     rd_data;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;

	logic            exec_we;
	logic [31:0]     exec_wdata;
	logic [31:0]     sum;
	logic            reject;
	logic signed [AW+1:0] np;
	logic [AW-1:0]   new_head;
	tmwp_pkg::rsp_t  exec_rsp;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = slot_free &&
		((state_q == ST_EXEC) || (state_q == ST_CLR && ptr_q == head_q));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// datapath of the single read-modify-write
	always_comb begin
		sum        = rd_data + item_q.amount;
		reject     = (item_q.amount > LIM) || (item_q.amount < -LIM);
		np         = $signed({2'b00, head_q}) + $signed(item_q.amount[AW+1:0]);
		if (np >= CNT_S) begin
			np = np - CNT_S;
		end else if (np < 0) begin
			np = np + CNT_S;
		end
		new_head   = head_q;
		exec_we    = 1'b0;
		exec_wdata = sum;
		exec_rsp   = '0;
		case (item_q.opcode)
			tmwp_pkg::OP_ADD: begin
				exec_we               = 1'b1;
				exec_rsp.result_value = $signed(sum);
			end
			tmwp_pkg::OP_MOVE: begin
				if (reject) begin
					exec_rsp.move_rejected = 1'b1;
				end else begin
					new_head = np[AW-1:0];
				end
				exec_rsp.result_value = $signed(32'(new_head));
			end
			tmwp_pkg::OP_SET: begin
				exec_we               = 1'b1;
				exec_wdata            = {24'd0, item_q.byte_value};
				exec_rsp.result_value = $signed({24'd0, item_q.byte_value});
			end
			tmwp_pkg::OP_READ: begin
				exec_rsp.result_value = $signed(rd_data);
			end
			default: begin
				exec_rsp = '0;
			end
		endcase
	end

	// store write port: reset sweep, clear sweep or command write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = '0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_CLR: begin
				mem_we = (ptr_q != head_q);
			end
			ST_EXEC: begin
				mem_we    = exec_we && slot_free;
				mem_waddr = head_q;
				mem_wdata = exec_wdata;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	tmwp_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (head_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			item_q      <= '0;
			head_q      <= '0;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (ptr_q == LAST_A) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						item_q <= cmd;
						ptr_q  <= '0;
						state_q <= (cmd.opcode == tmwp_pkg::OP_CLEAR) ? ST_CLR : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						head_q      <= new_head;
						rsp_q       <= exec_rsp;
						state_q     <= ST_IDLE;
					end
				end
				ST_CLR: begin
					if (ptr_q != head_q) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (slot_free) begin
						head_q      <= '0;
						rsp_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TMWP_ASSERT_NOW(a_head_range, clk, arst_n, 1'b1, 32'(head_q) < 32'(CELL_COUNT), "head out of range")
	`TMWP_ASSERT_NOW(a_no_cmd_in_sweep, clk, arst_n, state_q == ST_INIT, cmd_stall && mem_we, "command taken during reset sweep")
	`TMWP_ASSERT_NOW(a_idle_no_write, clk, arst_n, state_q == ST_IDLE, !mem_we, "store written while idle")
	`TMWP_ASSERT_NEXT(a_reject_holds_head, clk, arst_n, state_q == ST_EXEC && slot_free && item_q.opcode == tmwp_pkg::OP_MOVE && reject, head_q == $past(head_q) && rsp.move_rejected, "rejected move changed head")
	`TMWP_ASSERT_NEXT(a_clear_done, clk, arst_n, state_q == ST_CLR && ptr_q == head_q && slot_free, head_q == '0 && rsp_valid && rsp.result_value == 0, "clear did not finish cleanly")

endmodule

[sim/tape_memory_with_wrapping_pointer_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for the tape unit: directed and random opcode beats against a tape model
module tape_memory_with_wrapping_pointer_unit_test;

	localparam int CELLS = 30000;
	// longest quiet stretch: reset sweep or a clear from the last cell, plus stalls
	localparam int QUIET_LIMIT = 100000;
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	tmwp_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	tmwp_pkg::rsp_t rsp;

	logic [31:0]    tape_cells [CELLS];
	int             tape_head;
	tmwp_pkg::rsp_t expected_rsp [$];
	tmwp_pkg::rsp_t due_rsp;
	int             mismatches;
	int             quiet_cycles;
	int             stall_left;
	bit             cmd_up;
	bit             idling_on;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	tape_memory_with_wrapping_pointer_unit #(
		.CELL_COUNT(CELLS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// applies one command to the tape copy and returns the beat it should give
	function automatic tmwp_pkg::rsp_t predict_tape_step(tmwp_pkg::cmd_t c);
		tmwp_pkg::rsp_t r;
		int             next_pos;
		r = '0;
		case (c.opcode)
			tmwp_pkg::OP_ADD: begin
				tape_cells[tape_head] = tape_cells[tape_head] + c.amount;
				r.result_value = tape_cells[tape_head];
			end
			tmwp_pkg::OP_MOVE: begin
				if (c.amount > CELLS - 1 || c.amount < -(CELLS - 1)) begin
					r.move_rejected = 1'b1;
				end else begin
					next_pos = tape_head + c.amount;
					if (next_pos >= CELLS)
						next_pos -= CELLS;
					else if (next_pos < 0)
						next_pos += CELLS;
					tape_head = next_pos;
				end
				r.result_value = tape_head;
			end
			tmwp_pkg::OP_SET: begin
				tape_cells[tape_head] = {24'd0, c.byte_value};
				r.result_value = tape_cells[tape_head];
			end
			tmwp_pkg::OP_READ: begin
				r.result_value = tape_cells[tape_head];
			end
			tmwp_pkg::OP_CLEAR: begin
				// the cell under the head survives
				for (int i = 0; i < tape_head; i++)
					tape_cells[i] = '0;
				tape_head = 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_cmd(input logic [2:0] op, input logic signed [31:0] amt,
			input logic [7:0] b);
		tmwp_pkg::cmd_t beat;
		int             gap;
		beat.opcode     = op;
		beat.amount     = amt;
		beat.byte_value = b;
		gap = 0;
		if (idling_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			if (cmd_up)
				cmd_valid <= 1'b0;
			cmd_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= beat;
		cmd_up     = 1'b1;
		do @(posedge clk); while (cmd_stall);
		expected_rsp.push_back(predict_tape_step(beat));
	endtask

	task automatic go_idle();
		if (cmd_up)
			cmd_valid <= 1'b0;
		cmd_up = 1'b0;
	endtask

	task automatic wait_drained();
		go_idle();
		do @(posedge clk); while (expected_rsp.size() != 0);
	endtask

	task automatic test_add_wrap();
		send_cmd(tmwp_pkg::OP_ADD, 32'sh7FFF_FFFF, 8'h00);
		send_cmd(tmwp_pkg::OP_ADD, 32'sd1, 8'hFF);
		send_cmd(tmwp_pkg::OP_ADD, 32'sh8000_0000, 8'h00);
		send_cmd(tmwp_pkg::OP_ADD, -32'sd1, 8'hFF);
		send_cmd(tmwp_pkg::OP_READ, 32'sd0, 8'h00);
	endtask

	task automatic test_set_byte();
		send_cmd(tmwp_pkg::OP_SET, -32'sd1, 8'hFF);
		send_cmd(tmwp_pkg::OP_SET, 32'sd0, 8'h00);
	endtask

	task automatic test_head_wrap();
		send_cmd(tmwp_pkg::OP_MOVE, -32'sd1, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, 32'sd1, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, CELLS - 1, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, -(CELLS - 1), 8'h00);
		// one past the limit either way, then the most negative offset
		send_cmd(tmwp_pkg::OP_MOVE, CELLS, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, -CELLS, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, 32'sh8000_0000, 8'h00);
	endtask

	task automatic test_clear_below_head();
		send_cmd(tmwp_pkg::OP_SET, 32'sd0, 8'h5A);
		send_cmd(tmwp_pkg::OP_MOVE, -32'sd1, 8'h00);
		send_cmd(tmwp_pkg::OP_SET, 32'sd0, 8'hA5);
		// full-length clear from the last cell
		send_cmd(tmwp_pkg::OP_CLEAR, 32'sd0, 8'h00);
		send_cmd(tmwp_pkg::OP_READ, 32'sd0, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, -32'sd1, 8'h00);
		send_cmd(tmwp_pkg::OP_READ, 32'sd0, 8'h00);
		send_cmd(tmwp_pkg::OP_MOVE, 32'sd1, 8'h00);
		send_cmd(tmwp_pkg::OP_CLEAR, 32'sd0, 8'h00);
	endtask

	task automatic test_unused_opcodes();
		for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
			send_cmd(3'(op), $urandom, 8'($urandom));
	endtask

	task automatic test_random_traffic(input int count);
		int                 pick;
		int                 sub;
		logic signed [31:0] amt;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			sub  = $urandom_range(0, 9);
			amt  = $urandom;
			if (pick < 22) begin
				if (sub < 3)
					amt = int'($urandom_range(0, 16)) - 8;
				send_cmd(tmwp_pkg::OP_ADD, amt, 8'($urandom));
			end else if (pick < 52) begin
				if (sub < 5) begin
					amt = int'($urandom_range(0, 16)) - 8;
				end else if (sub < 8) begin
					amt = $urandom_range(0, CELLS - 1);
					if ($urandom_range(0, 1))
						amt = -amt;
				end else if (sub == 8) begin
					amt = $urandom_range(CELLS, 32'h7FFF_FFFF);
					if ($urandom_range(0, 1))
						amt = -amt;
				end
				send_cmd(tmwp_pkg::OP_MOVE, amt, 8'($urandom));
			end else if (pick < 67) begin
				send_cmd(tmwp_pkg::OP_SET, amt, 8'($urandom));
			end else if (pick < 87) begin
				send_cmd(tmwp_pkg::OP_READ, amt, 8'($urandom));
			end else if (pick < 95) begin
				// bring the head near the start so the clear stays short
				if (tape_head > 64)
					send_cmd(tmwp_pkg::OP_MOVE, int'($urandom_range(0, 40)) - tape_head,
						8'($urandom));
				send_cmd(tmwp_pkg::OP_CLEAR, amt, 8'($urandom));
			end else begin
				send_cmd(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), amt,
					8'($urandom));
			end
		end
	endtask

	// result side: check each accepted beat and stall in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("result beat with none expected: result_value %0d",
						rsp.result_value);
					mismatches++;
				end else begin
					due_rsp = expected_rsp.pop_front();
					if (rsp.result_value !== due_rsp.result_value) begin
						$error("result_value: expected %0d, got %0d",
							due_rsp.result_value, rsp.result_value);
						mismatches++;
					end
					if (rsp.move_rejected !== due_rsp.move_rejected) begin
						$error("move_rejected: expected %0b, got %0b",
							due_rsp.move_rejected, rsp.move_rejected);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		foreach (tape_cells[i])
			tape_cells[i] = '0;
		tape_head = 0;
		idling_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_add_wrap();
		test_set_byte();
		test_head_wrap();
		test_clear_below_head();
		test_unused_opcodes();
		test_random_traffic(425);
		// hold the sender until every result is back
		wait_drained();
		idling_on = 1'b0;
		test_random_traffic(100);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
